[hw/rtl/aes_pkg.sv]
// AES-128 package: S-box tables, GF(2^8) helpers, round helpers.
// No dependencies; used by every RTL file of the block cipher.
`default_nettype none
package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned BlockW    = 128;
  localparam int unsigned HalfW     = 64;
  localparam int unsigned IdxW      = 1;
  localparam int unsigned SettleW   = 4;

  // Cycles the registered key chain needs to refill after a key write.
  localparam logic [SettleW-1:0] KeySettleCycles = SettleW'(NumRounds);

  localparam logic [IdxW-1:0] RegKeyHigh = 1'b0;
  localparam logic [IdxW-1:0] RegKeyLow  = 1'b1;

  localparam logic ReqEncrypt = 1'b0;
  localparam logic ReqDecrypt = 1'b1;

  localparam logic [7:0] GfReduce = 8'h1b;

  localparam logic [7:0] FwdSub [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

  localparam logic [7:0] RevSub [256] = '{
    8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
    8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
    8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
    8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
    8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
    8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
    8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
    8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
    8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
    8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
    8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
    8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
    8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
    8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
    8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
  };

  localparam logic [7:0] RoundConst [NumRounds] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  // Byte 4c+r of the block (row r, column c) sits at bits 127-8*(4c+r).
  function automatic logic [7:0] get_byte(logic [BlockW-1:0] s, int unsigned i);
    return s[BlockW-1-8*i -: 8];
  endfunction

  function automatic logic [7:0] xtime(logic [7:0] b);
    return b[7] ? ({b[6:0], 1'b0} ^ GfReduce) : {b[6:0], 1'b0};
  endfunction

  function automatic logic [BlockW-1:0] sub_shift(logic [BlockW-1:0] s, logic rev);
    logic [BlockW-1:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (rev) begin
          t[BlockW-1-8*(((c+r)%4)*4+r) -: 8] = RevSub[get_byte(s, c*4+r)];
        end else begin
          t[BlockW-1-8*(c*4+r) -: 8] = FwdSub[get_byte(s, ((c+r)%4)*4+r)];
        end
      end
    end
    return t;
  endfunction

  function automatic logic [BlockW-1:0] mix(logic [BlockW-1:0] s, logic rev);
    logic [BlockW-1:0] t;
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m  [4];
    logic [7:0] acc;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        a[k]  = get_byte(s, c*4+k);
        x2[k] = xtime(a[k]);
        x4[k] = xtime(x2[k]);
        x8[k] = xtime(x4[k]);
      end
      for (int r = 0; r < 4; r++) begin
        for (int k = 0; k < 4; k++) begin
          case ((k - r + 4) % 4)
            0: m[k] = rev ? (x8[k] ^ x4[k] ^ x2[k]) : x2[k];
            1: m[k] = rev ? (x8[k] ^ x2[k] ^ a[k]) : (x2[k] ^ a[k]);
            2: m[k] = rev ? (x8[k] ^ x4[k] ^ a[k]) : a[k];
            default: m[k] = rev ? (x8[k] ^ a[k]) : a[k];
          endcase
        end
        acc = m[0] ^ m[1] ^ m[2] ^ m[3];
        t[BlockW-1-8*(c*4+r) -: 8] = acc;
      end
    end
    return t;
  endfunction

  // One key expansion step: round key i -> round key i+1.
  function automatic logic [BlockW-1:0] next_key(logic [BlockW-1:0] k, logic [7:0] rcon);
    logic [31:0] w [4];
    logic [31:0] t;
    for (int j = 0; j < 4; j++) w[j] = k[BlockW-1-32*j -: 32];
    t = {FwdSub[w[3][23:16]] ^ rcon, FwdSub[w[3][15:8]], FwdSub[w[3][7:0]],
         FwdSub[w[3][31:24]]};
    w[0] = w[0] ^ t;
    w[1] = w[1] ^ w[0];
    w[2] = w[2] ^ w[1];
    w[3] = w[3] ^ w[2];
    return {w[0], w[1], w[2], w[3]};
  endfunction

  typedef struct packed {
    logic             vld;
    logic             dec;
    logic [BlockW-1:0] data;
  } aes_stage_t;

endpackage
`default_nettype wire

[hw/rtl/aes_if.sv]
// Valid/ready stream interfaces for the block cipher.
// Depends on aes_pkg for widths.
`default_nettype none
interface aes_req_if import aes_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [HalfW-1:0] block_high;
  logic [HalfW-1:0] block_low;
  modport source (output valid, req_type, block_high, block_low, input ready);
  modport sink   (input valid, req_type, block_high, block_low, output ready);
endinterface

interface aes_rsp_if import aes_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [HalfW-1:0] result_high;
  logic [HalfW-1:0] result_low;
  modport source (output valid, result_high, result_low, input ready);
  modport sink   (input valid, result_high, result_low, output ready);
endinterface

interface aes_cfg_if import aes_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IdxW-1:0]  index;
  logic [HalfW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hw/rtl/aes_round_cell.sv]
// One round cell of the cipher chain: a full round for encrypt or decrypt.
// Depends on aes_pkg.
`default_nettype none
module aes_round_cell import aes_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              last_i,
  input  wire aes_stage_t        stage_i,
  input  wire logic [BlockW-1:0] key_i,
  output      aes_stage_t        stage_o
);
  logic [BlockW-1:0] enc_ss, enc_res, dec_ss, dec_x, dec_res;
  aes_stage_t        stage_d, stage_q;

  // Encrypt: SubBytes/ShiftRows, MixColumns (not in last round), AddRoundKey.
  // Decrypt: InvShiftRows/InvSubBytes, AddRoundKey, InvMixColumns (not in last).
  always_comb begin
    enc_ss        = sub_shift(stage_i.data, 1'b0);
    enc_res       = (last_i ? enc_ss : mix(enc_ss, 1'b0)) ^ key_i;
    dec_ss        = sub_shift(stage_i.data, 1'b1);
    dec_x         = dec_ss ^ key_i;
    dec_res       = last_i ? dec_x : mix(dec_x, 1'b1);
    stage_d.vld   = stage_i.vld;
    stage_d.dec   = stage_i.dec;
    stage_d.data  = stage_i.dec ? dec_res : enc_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;
endmodule
`default_nettype wire

[hw/rtl/aes_key_cell.sv]
// One key expansion cell: derives the next round key, registered.
// Depends on aes_pkg.
`default_nettype none
module aes_key_cell import aes_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic [BlockW-1:0] key_i,
  input  wire logic [7:0]        rcon_i,
  output      logic [BlockW-1:0] key_o
);
  logic [BlockW-1:0] key_d, key_q;
  assign key_d = next_key(key_i, rcon_i);
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end
  assign key_o = key_q;
endmodule
`default_nettype wire

[hw/rtl/aes128_block_cipher.sv]
// AES-128 ECB block cipher, top level: config, key chain, round chain, output.
// Depends on aes_pkg, aes_if, aes_round_cell and aes_key_cell.
//
// Usage:
//   cfg channel: write index 0 (key_high) and 1 (key_low); other indexes are
//   dropped. Writes are always accepted. Write the key only while idle. The
//   round keys ripple through a registered chain of 10 key cells, so req.ready
//   stays low after each key write while the chain refills.
//   req channel: one block per transaction, req_type 0 encrypts, 1 decrypts.
//   rsp channel: one result per transaction, in request order.
// Pipeline: an input register, ten round cells, and the output register.
// Throughput: one block per cycle while the chain is not stalled; every round
// is a cell of its own in the chain.
// Stall: the whole chain advances together; when the output register holds
// a result the receiver has not taken, the chain holds and req.ready drops.
// Reset: the key clears to zero and all valid flags clear; req.ready rises
// once the key chain holds the zero key after reset is released.
`default_nettype none
module aes128_block_cipher import aes_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  aes_cfg_if.sink   cfg_i,
  aes_req_if.sink   req_i,
  aes_rsp_if.source rsp_o
);
  logic [HalfW-1:0] key_high_q, key_low_q;
  logic [BlockW-1:0] rk [NumRounds+1];
  aes_stage_t chain [NumRounds+1];
  aes_stage_t in_d, in_q;
  logic       out_vld_q;
  logic [BlockW-1:0] out_data_q;
  logic       adv;
  logic [SettleW-1:0] settle_d, settle_q;
  logic       key_rdy;

  // Config port: always ready, drop unknown indexes.
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        RegKeyHigh: key_high_q <= cfg_i.data;
        RegKeyLow:  key_low_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Hold requests off until the key chain has refilled after reset or a write.
  always_comb begin
    settle_d = settle_q;
    if (cfg_i.valid && cfg_i.ready) begin
      settle_d = KeySettleCycles;
    end else if (settle_q != '0) begin
      settle_d = settle_q - 1'b1;
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= KeySettleCycles;
    end else begin
      settle_q <= settle_d;
    end
  end
  assign key_rdy = (settle_q == '0);

  // Key chain: rk[i] is round key i.
  assign rk[0] = {key_high_q, key_low_q};
  for (genvar g = 0; g < NumRounds; g++) begin : g_key
    aes_key_cell u_key (
      .clk_i (clk_i),
      .key_i (rk[g]),
      .rcon_i(RoundConst[g]),
      .key_o (rk[g+1])
    );
  end

  // Advance the chain unless the output register holds an untaken result.
  assign adv = !out_vld_q || rsp_o.ready;
  assign req_i.ready = adv && key_rdy;

  // Input register: initial AddRoundKey (key 0 to encrypt, key 10 to decrypt).
  always_comb begin
    in_d.vld  = req_i.valid && key_rdy;
    in_d.dec  = req_i.req_type;
    in_d.data = {req_i.block_high, req_i.block_low} ^
                ((req_i.req_type == ReqDecrypt) ? rk[NumRounds] : rk[0]);
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q <= '0;
    end else if (adv) begin
      in_q <= in_d;
    end
  end

  assign chain[0] = in_q;
  for (genvar g = 0; g < NumRounds; g++) begin : g_round
    logic [BlockW-1:0] key_sel;
    // Encrypt round g+1 uses key g+1; decrypt cell g uses key NumRounds-1-g.
    assign key_sel = chain[g].dec ? rk[NumRounds-1-g] : rk[g+1];
    aes_round_cell u_round (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .last_i (g == NumRounds-1),
      .stage_i(chain[g]),
      .key_i  (key_sel),
      .stage_o(chain[g+1])
    );
  end

  // Output register: a result waits here until taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= chain[NumRounds].vld;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= chain[NumRounds].data;
    end
  end

  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.result_high = out_data_q[BlockW-1 -: HalfW];
  assign rsp_o.result_low  = out_data_q[HalfW-1:0];

  // A held result must stay put while the receiver stalls.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !rsp_o.ready |=> out_vld_q && $stable(out_data_q))
    else $error("result changed while stalled");
  // An accepted request always enters the input stage.
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> in_q.vld)
    else $error("accepted request lost");
  // A chain freeze only happens while a result waits.
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |-> out_vld_q)
    else $error("chain stalled without pending result");
endmodule
`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the AES-128 ECB block cipher.
// It checks every result against an AES predictor built into this file.
// It depends on aes_pkg (S-box and round-constant tables) and on the aes_if stream interfaces.
`default_nettype none
module tb;
  import aes_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned KeySettle = 14;   // key chain ripple plus margin
  localparam int unsigned DrainWait = 20;   // pipeline latency plus margin
  localparam int unsigned StallLimit = 5000;

  typedef struct packed {
    logic [HalfW-1:0] hi;
    logic [HalfW-1:0] lo;
  } block_t;

  logic clk_i;
  logic rst_ni;

  aes_cfg_if cfg ();
  aes_req_if req ();
  aes_rsp_if rsp ();

  aes128_block_cipher i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // Predictor state: the key as the block should hold it.
  logic [BlockW-1:0] cipher_key;
  block_t            pending_results[$];
  logic              idle_on;
  int unsigned       err_cnt;
  int unsigned       stall_cnt;

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // ---------------------------------------------------------------------------
  // AES predictor
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] m);
    logic [7:0] acc;
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      if (m[i]) acc ^= a;
      a = a[7] ? ({a[6:0], 1'b0} ^ GfReduce) : {a[6:0], 1'b0};
    end
    return acc;
  endfunction

  // Forward: substitute, then rotate row r left by r. Inverse: rotate right, then substitute.
  function automatic logic [BlockW-1:0] shift_sub(logic [BlockW-1:0] s, logic inv);
    logic [BlockW-1:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inv) begin
          t[BlockW-1-8*(((c+r)%4)*4+r) -: 8] = RevSub[s[BlockW-1-8*(c*4+r) -: 8]];
        end else begin
          t[BlockW-1-8*(c*4+r) -: 8] = FwdSub[s[BlockW-1-8*(((c+r)%4)*4+r) -: 8]];
        end
      end
    end
    return t;
  endfunction

  function automatic logic [BlockW-1:0] column_mix(logic [BlockW-1:0] s, logic inv);
    logic [7:0] coef [4];
    logic [7:0] acc;
    logic [BlockW-1:0] t;
    if (inv) begin
      coef = '{8'd14, 8'd11, 8'd13, 8'd9};
    end else begin
      coef = '{8'd2, 8'd3, 8'd1, 8'd1};
    end
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        acc = '0;
        for (int k = 0; k < 4; k++) begin
          acc ^= gf_mul(s[BlockW-1-8*(c*4+k) -: 8], coef[(k-r+4)%4]);
        end
        t[BlockW-1-8*(c*4+r) -: 8] = acc;
      end
    end
    return t;
  endfunction

  function automatic logic [BlockW-1:0] aes_cipher(logic [BlockW-1:0] key,
                                                   logic [BlockW-1:0] blk, logic inv);
    logic [BlockW-1:0] rk [NumRounds+1];
    logic [31:0] w [4];
    logic [31:0] t;
    logic [BlockW-1:0] s;
    rk[0] = key;
    for (int i = 1; i <= NumRounds; i++) begin
      for (int j = 0; j < 4; j++) w[j] = rk[i-1][BlockW-1-32*j -: 32];
      t = {FwdSub[w[3][23:16]] ^ RoundConst[i-1], FwdSub[w[3][15:8]],
           FwdSub[w[3][7:0]], FwdSub[w[3][31:24]]};
      for (int j = 0; j < 4; j++) begin
        w[j] ^= t;
        t = w[j];
      end
      rk[i] = {w[0], w[1], w[2], w[3]};
    end
    if (!inv) begin
      s = blk ^ rk[0];
      for (int r = 1; r < NumRounds; r++) s = column_mix(shift_sub(s, 1'b0), 1'b0) ^ rk[r];
      s = shift_sub(s, 1'b0) ^ rk[NumRounds];
    end else begin
      s = shift_sub(blk ^ rk[NumRounds], 1'b1);
      for (int r = NumRounds - 1; r >= 1; r--) begin
        s = shift_sub(column_mix(s ^ rk[r], 1'b1), 1'b1);
      end
      s = s ^ rk[0];
    end
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Receiver side: stall at random while idling is enabled.
  always @(posedge clk_i) begin
    rsp.ready <= !idle_on || ($urandom_range(99) >= 35);
  end

  // Send one block. Valid stays high after the transaction so that back-to-back
  // blocks never lower and raise it in the same step; a gap lowers it first.
  task automatic send_block(logic dec, logic [HalfW-1:0] hi, logic [HalfW-1:0] lo);
    logic [BlockW-1:0] res;
    if (idle_on && $urandom_range(99) < 35) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    req.valid      <= 1'b1;
    req.req_type   <= dec;
    req.block_high <= hi;
    req.block_low  <= lo;
    do @(posedge clk_i); while (!req.ready);
    res = aes_cipher(cipher_key, {hi, lo}, dec);
    pending_results.push_back('{hi: res[BlockW-1 -: HalfW], lo: res[HalfW-1:0]});
  endtask

  // Hold until every expected result has come back and the pipeline is empty.
  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending_results.size() == 0);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // Write one key register while idle, then let the key chain settle.
  task automatic write_key(logic [IdxW-1:0] idx, logic [HalfW-1:0] value);
    drain();
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    if (idx == RegKeyHigh) cipher_key[BlockW-1 -: HalfW] = value;
    else cipher_key[HalfW-1:0] = value;
    repeat (KeySettle) @(posedge clk_i);
  endtask

  task automatic load_key(logic [BlockW-1:0] key);
    write_key(RegKeyHigh, key[BlockW-1 -: HalfW]);
    write_key(RegKeyLow, key[HalfW-1:0]);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    block_t exp_res;
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h_%h", $realtime, rsp.result_high, rsp.result_low);
        err_cnt++;
      end else begin
        exp_res = pending_results.pop_front();
        if (rsp.result_high !== exp_res.hi) begin
          $display("%0t: result_high expected %h actual %h",
                   $realtime, exp_res.hi, rsp.result_high);
          err_cnt++;
        end
        if (rsp.result_low !== exp_res.lo) begin
          $display("%0t: result_low expected %h actual %h",
                   $realtime, exp_res.lo, rsp.result_low);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: restart on any transaction, give up after a long quiet stretch.
  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= StallLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // The key is never written here, so the all-zero reset key must be in use.
  task automatic test_reset_key();
    send_block(ReqEncrypt, '0, '0);
    send_block(ReqDecrypt, '0, '0);
    send_block(ReqEncrypt, '1, '1);
    send_block(ReqDecrypt, '1, '1);
  endtask

  // Known-answer vector from the standard, both directions, plus two more blocks under its key.
  task automatic test_known_vector();
    load_key(128'h000102030405060708090a0b0c0d0e0f);
    send_block(ReqEncrypt, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(ReqDecrypt, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    send_block(ReqEncrypt, 64'h8000000000000000, 64'h0000000000000001);
    send_block(ReqDecrypt, 64'h0000000000000001, 64'h8000000000000000);
  endtask

  // Extreme keys and blocks, each under both request types.
  task automatic test_extremes();
    load_key('1);
    for (int i = 0; i < 4; i++) begin
      send_block(i[0], '0, '1);
      send_block(i[0], i[1] ? '1 : '0, i[1] ? '0 : '1);
    end
    load_key({64'haaaaaaaaaaaaaaaa, 64'h5555555555555555});
    send_block(ReqEncrypt, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    send_block(ReqDecrypt, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
  endtask

  // Random blocks under a given key; a pause midway, if asked for, lets every result drain.
  task automatic test_random_phase(logic [BlockW-1:0] key, int unsigned n, bit pause_mid);
    logic [HalfW-1:0] hi;
    logic [HalfW-1:0] lo;
    load_key(key);
    for (int unsigned i = 0; i < n; i++) begin
      hi = {$urandom, $urandom};
      lo = {$urandom, $urandom};
      if ($urandom_range(19) == 0) hi = $urandom_range(1) ? '1 : '0;
      if ($urandom_range(19) == 0) lo = $urandom_range(1) ? '1 : '0;
      send_block(1'($urandom_range(1)), hi, lo);
      if (pause_mid && i == n / 2) drain();
    end
  endtask

  initial begin
    rst_ni     = 1'b0;
    idle_on    = 1'b1;
    err_cnt    = 0;
    stall_cnt  = 0;
    cipher_key = '0;
    cfg.valid  = 1'b0;
    cfg.index  = RegKeyHigh;
    cfg.data   = '0;
    req.valid  = 1'b0;
    req.req_type   = ReqEncrypt;
    req.block_high = '0;
    req.block_low  = '0;
    rsp.ready  = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_key();
    test_known_vector();
    test_extremes();
    test_random_phase({$urandom, $urandom, $urandom, $urandom}, 120, 1'b1);
    // Long stretch with no idling on either side.
    idle_on = 1'b0;
    test_random_phase({$urandom, $urandom, $urandom, $urandom}, 120, 1'b0);
    idle_on = 1'b1;
    test_random_phase('0, 120, 1'b0);
    test_random_phase('1, 120, 1'b1);
    test_random_phase({$urandom, $urandom, $urandom, $urandom}, 120, 1'b0);

    drain();
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire

[files.f]
hw/rtl/aes_pkg.sv
hw/rtl/aes_if.sv
hw/rtl/aes_round_cell.sv
hw/rtl/aes_key_cell.sv
hw/rtl/aes128_block_cipher.sv
tb/tb.sv
